@@ src/pmtt_pkg.sv @@
// Package for the periodic timer table.
// Holds command and result codes, default sizes and the limit register reset value.
// No dependencies.
package pmtt_pkg;

    localparam int DEF_MAX_TIMERS = 16;
    localparam int DEF_TICK_BITS  = 16;

    localparam int CMD_W      = 2;
    localparam int INTERVAL_W = 16;
    localparam int KIND_W     = 3;
    localparam int NUM_W      = 5;
    localparam int LIMIT_W    = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_IDLE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEARED = 3'd4;

endpackage

@@ src/pmtt_ram.sv @@
// Timer entry memory: one write port, one read port with registered read data.
// Each word packs a timer's period (upper half) and elapsed count (lower half).
// Uses no package.
module pmtt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/periodic_multi_timer_table.sv @@
// Top level of the periodic timer table: command sequencer, tick scan unit, output register.
// Depends on pmtt_pkg and pmtt_ram.
//
// Usage:
//   Command channel: an item (i_command, i_interval) is taken at a rising edge with start
//   high and busy low. Commands: add a timer, tick, clear all timers; code 3 is ignored.
//   Result channel: each result word sits on o_kind, o_timer_number, o_last for one cycle
//   with o_valid high; o_last marks the final word of a command. The receiver cannot stall.
//   Limit register: i_cfg_we writes i_cfg_data into the timer limit; write only while idle.
// Operation:
//   Add and clear complete from idle; their result word appears the cycle after start,
//   and busy stays low, so a new command may follow at once.
//   A tick on a table of N timers holds busy through a scan and a flush state: one memory
//   read-modify-write per timer, newest first, through a single increment and compare unit,
//   then the flush releases the held expiry word with its last flag, or an idle word if no
//   timer expired. With no timers the tick answers from idle with an idle word. Each expiry
//   word is held until the next expiry or the end of the scan.
// Reset:
//   Synchronous, active low. Empties the table, sets the limit to 16, clears the
//   sequencer and drops o_valid. Timer memory is not cleared; it is written by add.
module periodic_multi_timer_table #(
    parameter int MAX_TIMERS = pmtt_pkg::DEF_MAX_TIMERS,
    parameter int TICK_BITS  = pmtt_pkg::DEF_TICK_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [pmtt_pkg::CMD_W-1:0]      i_command,
    input  logic [pmtt_pkg::INTERVAL_W-1:0] i_interval,
    input  logic                            i_cfg_we,
    input  logic [pmtt_pkg::LIMIT_W-1:0]    i_cfg_data,
    output logic                            o_valid,
    output logic [pmtt_pkg::KIND_W-1:0]     o_kind,
    output logic [pmtt_pkg::NUM_W-1:0]      o_timer_number,
    output logic                            o_last
);

    localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam int DW = 2 * TICK_BITS;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]                         r_state, n_state;
    logic [IW-1:0]                      r_idx, n_idx;
    logic [CW-1:0]                      r_count, n_count;
    logic                               r_pend_vld, n_pend_vld;
    logic [CW-1:0]                      r_pend_num, n_pend_num;
    logic [pmtt_pkg::LIMIT_W-1:0]       r_limit;
    logic                               r_valid, n_valid;
    logic [pmtt_pkg::KIND_W-1:0]        r_kind, n_kind;
    logic [pmtt_pkg::NUM_W-1:0]         r_num, n_num;
    logic                               r_last, n_last;

    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [DW-1:0]       wr_data;
    logic [IW-1:0]       rd_addr;
    logic [DW-1:0]       rd_data;

    logic [31:0]         ival_ext;
    logic [TICK_BITS-1:0] ival;
    logic [31:0]         limit_eff;
    logic                table_full;
    logic [TICK_BITS-1:0] period;
    logic [TICK_BITS-1:0] elapsed_inc;
    logic                hit;

    pmtt_ram #(
        .DEPTH (MAX_TIMERS),
        .WIDTH (DW),
        .AW    (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign ival_ext    = {16'd0, i_interval};
    assign ival        = ival_ext[TICK_BITS-1:0];
    assign limit_eff   = (32'(r_limit) > 32'(MAX_TIMERS)) ? 32'(MAX_TIMERS) : 32'(r_limit);
    assign table_full  = 32'(r_count) >= limit_eff;
    assign period      = rd_data[DW-1:TICK_BITS];
    assign elapsed_inc = rd_data[TICK_BITS-1:0] + TICK_BITS'(1);
    assign hit         = elapsed_inc >= period;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_count    = r_count;
        n_pend_vld = r_pend_vld;
        n_pend_num = r_pend_num;
        n_valid    = 1'b0;
        n_kind     = r_kind;
        n_num      = r_num;
        n_last     = r_last;
        wr_en      = 1'b0;
        wr_addr    = r_idx;
        wr_data    = {period, elapsed_inc};
        rd_addr    = IW'(r_idx - IW'(1));

        unique case (r_state)
            S_IDLE: begin
                rd_addr = IW'(r_count - CW'(1));
                if (start) begin
                    case (i_command)
                        pmtt_pkg::CMD_ADD: begin
                            n_valid = 1'b1;
                            n_last  = 1'b1;
                            if (ival == '0 || table_full) begin
                                n_kind = pmtt_pkg::KIND_REFUSED;
                                n_num  = '0;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = IW'(r_count);
                                wr_data = {ival, {TICK_BITS{1'b0}}};
                                n_count = r_count + CW'(1);
                                n_kind  = pmtt_pkg::KIND_ADDED;
                                n_num   = pmtt_pkg::NUM_W'(r_count + CW'(1));
                            end
                        end
                        pmtt_pkg::CMD_TICK: begin
                            if (r_count == '0) begin
                                n_valid = 1'b1;
                                n_last  = 1'b1;
                                n_kind  = pmtt_pkg::KIND_IDLE;
                                n_num   = '0;
                            end else begin
                                n_state    = S_SCAN;
                                n_idx      = IW'(r_count - CW'(1));
                                n_pend_vld = 1'b0;
                            end
                        end
                        pmtt_pkg::CMD_CLEAR: begin
                            n_count = '0;
                            n_valid = 1'b1;
                            n_last  = 1'b1;
                            n_kind  = pmtt_pkg::KIND_CLEARED;
                            n_num   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                wr_en   = 1'b1;
                wr_data = {period, hit ? {TICK_BITS{1'b0}} : elapsed_inc};
                if (hit) begin
                    if (r_pend_vld) begin
                        n_valid = 1'b1;
                        n_last  = 1'b0;
                        n_kind  = pmtt_pkg::KIND_EXPIRED;
                        n_num   = pmtt_pkg::NUM_W'(r_pend_num);
                    end
                    n_pend_vld = 1'b1;
                    n_pend_num = CW'(r_idx) + CW'(1);
                end
                if (r_idx == '0) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx = r_idx - IW'(1);
                end
            end
            S_FLUSH: begin
                n_valid = 1'b1;
                n_last  = 1'b1;
                if (r_pend_vld) begin
                    n_kind = pmtt_pkg::KIND_EXPIRED;
                    n_num  = pmtt_pkg::NUM_W'(r_pend_num);
                end else begin
                    n_kind = pmtt_pkg::KIND_IDLE;
                    n_num  = '0;
                end
                n_pend_vld = 1'b0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_pend_vld <= 1'b0;
            r_valid    <= 1'b0;
            r_limit    <= pmtt_pkg::LIMIT_RESET;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pend_vld <= n_pend_vld;
            r_valid    <= n_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pend_num <= n_pend_num;
        r_kind     <= n_kind;
        r_num      <= n_num;
        r_last     <= n_last;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_timer_number = r_num;
    assign o_last         = r_last;

endmodule

@@ tb/tb_periodic_multi_timer_table.sv @@
// Self-checking testbench for the periodic timer table: add, tick and clear commands
// against a cycle-free predictor, with limit register phases and random sender idling.
// Depends on pmtt_pkg and periodic_multi_timer_table.
`timescale 1ns / 1ps

module tb_periodic_multi_timer_table;

    localparam logic [pmtt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 2 * pmtt_pkg::DEF_MAX_TIMERS + 8;
    localparam int PRINT_CAP     = 40;

    typedef struct packed {
        logic [pmtt_pkg::CMD_W-1:0]      cmd;
        logic [pmtt_pkg::INTERVAL_W-1:0] ival;
    } t_timer_cmd;

    typedef struct packed {
        logic [pmtt_pkg::KIND_W-1:0] kind;
        logic [pmtt_pkg::NUM_W-1:0]  num;
        logic                        last;
    } t_timer_event;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic [pmtt_pkg::CMD_W-1:0]      i_command;
    logic [pmtt_pkg::INTERVAL_W-1:0] i_interval;
    logic                            i_cfg_we;
    logic [pmtt_pkg::LIMIT_W-1:0]    i_cfg_data;
    logic                            o_valid;
    logic [pmtt_pkg::KIND_W-1:0]     o_kind;
    logic [pmtt_pkg::NUM_W-1:0]      o_timer_number;
    logic                            o_last;

    periodic_multi_timer_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_interval     (i_interval),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_timer_number (o_timer_number),
        .o_last         (o_last)
    );

    t_timer_cmd   cmd_backlog[$];
    t_timer_event events_due[$];
    t_timer_cmd   next_cmd;

    logic [pmtt_pkg::INTERVAL_W-1:0] period_m [pmtt_pkg::DEF_MAX_TIMERS];
    logic [pmtt_pkg::INTERVAL_W-1:0] elapsed_m[pmtt_pkg::DEF_MAX_TIMERS];
    logic [pmtt_pkg::NUM_W-1:0]      count_m;
    logic [pmtt_pkg::LIMIT_W-1:0]    limit_m;

    bit took;
    int idle_pct;
    int mismatches;
    int cmds_taken;
    int words_checked;
    int expiries_seen;
    int refusals_seen;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic push_event(logic [pmtt_pkg::KIND_W-1:0] kind,
                              logic [pmtt_pkg::NUM_W-1:0] num, logic last);
        t_timer_event ev;
        ev.kind = kind;
        ev.num  = num;
        ev.last = last;
        events_due.push_back(ev);
    endtask

    task automatic model_timer_command(logic [pmtt_pkg::CMD_W-1:0] cmd,
                                       logic [pmtt_pkg::INTERVAL_W-1:0] ival);
        int cap;
        int fired[$];
        cap = (int'(limit_m) > pmtt_pkg::DEF_MAX_TIMERS) ?
              pmtt_pkg::DEF_MAX_TIMERS : int'(limit_m);
        case (cmd)
            pmtt_pkg::CMD_ADD: begin
                if (ival == '0 || int'(count_m) >= cap) begin
                    push_event(pmtt_pkg::KIND_REFUSED, '0, 1'b1);
                end else begin
                    period_m[count_m]  = ival;
                    elapsed_m[count_m] = '0;
                    count_m++;
                    push_event(pmtt_pkg::KIND_ADDED, count_m, 1'b1);
                end
            end
            pmtt_pkg::CMD_TICK: begin
                for (int i = int'(count_m) - 1; i >= 0; i--) begin
                    elapsed_m[i] = elapsed_m[i] + 1'b1;
                    if (elapsed_m[i] >= period_m[i]) begin
                        elapsed_m[i] = '0;
                        fired.push_back(i + 1);
                    end
                end
                if (fired.size() == 0)
                    push_event(pmtt_pkg::KIND_IDLE, '0, 1'b1);
                for (int k = 0; k < fired.size(); k++)
                    push_event(pmtt_pkg::KIND_EXPIRED, pmtt_pkg::NUM_W'(fired[k]),
                               k == fired.size() - 1);
            end
            pmtt_pkg::CMD_CLEAR: begin
                count_m = '0;
                push_event(pmtt_pkg::KIND_CLEARED, '0, 1'b1);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_timer_event want;
        took = 1'b0;
        if (!i_rst_n) begin
            count_m = '0;
            limit_m = pmtt_pkg::LIMIT_RESET;
        end else begin
            if (o_valid) begin
                if (events_due.size() == 0) begin
                    report_mismatch("result word with nothing due, kind", o_kind, 0);
                end else begin
                    want = events_due.pop_front();
                    words_checked++;
                    if (o_kind == pmtt_pkg::KIND_EXPIRED)
                        expiries_seen++;
                    if (o_kind == pmtt_pkg::KIND_REFUSED)
                        refusals_seen++;
                    if (o_kind !== want.kind)
                        report_mismatch("kind", o_kind, want.kind);
                    if (o_timer_number !== want.num)
                        report_mismatch("timer_number", o_timer_number, want.num);
                    if (o_last !== want.last)
                        report_mismatch("last", o_last, want.last);
                end
            end
            if (i_cfg_we)
                limit_m = i_cfg_data;
            if (start && !busy) begin
                model_timer_command(i_command, i_interval);
                cmds_taken++;
                took = 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start      <= 1'b0;
            i_command  <= '0;
            i_interval <= '0;
        end else if (!start || took) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_cmd = cmd_backlog.pop_front();
                start      <= 1'b1;
                i_command  <= next_cmd.cmd;
                i_interval <= next_cmd.ival;
            end else begin
                start      <= 1'b0;
                i_command  <= pmtt_pkg::CMD_W'($urandom);
                i_interval <= pmtt_pkg::INTERVAL_W'($urandom);
            end
        end
    end

    task automatic queue_cmd(logic [pmtt_pkg::CMD_W-1:0] cmd,
                             logic [pmtt_pkg::INTERVAL_W-1:0] ival);
        t_timer_cmd c;
        c.cmd  = cmd;
        c.ival = ival;
        cmd_backlog.push_back(c);
    endtask

    task automatic settle();
        do @(posedge i_clk); while (cmd_backlog.size() != 0 || start);
        while (events_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [pmtt_pkg::LIMIT_W-1:0] value);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= pmtt_pkg::LIMIT_W'($urandom);
    endtask

    function automatic logic [pmtt_pkg::INTERVAL_W-1:0] pick_interval();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        else if (r < 70)
            return pmtt_pkg::INTERVAL_W'($urandom_range(6, 1));
        else if (r < 90)
            return pmtt_pkg::INTERVAL_W'($urandom_range(40, 1));
        return pmtt_pkg::INTERVAL_W'($urandom);
    endfunction

    task automatic queue_random(int n, int clear_pct);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < clear_pct)
                queue_cmd(pmtt_pkg::CMD_CLEAR, pmtt_pkg::INTERVAL_W'($urandom));
            else if (r < clear_pct + 4)
                queue_cmd(CMD_UNUSED, pmtt_pkg::INTERVAL_W'($urandom));
            else if (r < clear_pct + 44)
                queue_cmd(pmtt_pkg::CMD_ADD, pick_interval());
            else
                queue_cmd(pmtt_pkg::CMD_TICK, pmtt_pkg::INTERVAL_W'($urandom));
        end
    endtask

    task automatic run_random(logic [pmtt_pkg::LIMIT_W-1:0] limit, int idle, int n,
                              int clear_pct);
        write_limit(limit);
        idle_pct = idle;
        queue_random(n, clear_pct);
    endtask

    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        idle_pct   = 18;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, zero interval, extreme intervals, unused code
        queue_cmd(pmtt_pkg::CMD_TICK, 16'hFFFF);
        queue_cmd(pmtt_pkg::CMD_ADD, 16'h0000);
        queue_cmd(pmtt_pkg::CMD_ADD, 16'h0001);
        queue_cmd(pmtt_pkg::CMD_ADD, 16'hFFFF);
        queue_cmd(pmtt_pkg::CMD_ADD, 16'h0002);
        queue_cmd(pmtt_pkg::CMD_ADD, 16'h0003);
        queue_cmd(pmtt_pkg::CMD_TICK, 16'h0000);
        queue_cmd(pmtt_pkg::CMD_TICK, 16'hAAAA);
        queue_cmd(pmtt_pkg::CMD_TICK, 16'h5555);
        queue_cmd(CMD_UNUSED, 16'hFFFF);
        queue_cmd(pmtt_pkg::CMD_TICK, 16'h0000);
        queue_cmd(pmtt_pkg::CMD_CLEAR, 16'hFFFF);
        queue_cmd(pmtt_pkg::CMD_TICK, 16'h0000);

        // small limit, full table, then limit dropped below the count
        write_limit(5'd2);
        queue_cmd(pmtt_pkg::CMD_ADD, 16'h0005);
        queue_cmd(pmtt_pkg::CMD_ADD, 16'h0001);
        queue_cmd(pmtt_pkg::CMD_ADD, 16'h0007);
        queue_cmd(pmtt_pkg::CMD_TICK, 16'h0000);
        queue_cmd(pmtt_pkg::CMD_TICK, 16'h0000);
        write_limit(5'd0);
        queue_cmd(pmtt_pkg::CMD_ADD, 16'h0009);
        queue_cmd(pmtt_pkg::CMD_TICK, 16'h0000);
        queue_cmd(pmtt_pkg::CMD_CLEAR, 16'h0000);
        queue_cmd(pmtt_pkg::CMD_ADD, 16'h0004);

        // limit above the table size: fill all entries, one more add
        write_limit(5'd31);
        for (int k = 0; k < pmtt_pkg::DEF_MAX_TIMERS + 1; k++)
            queue_cmd(pmtt_pkg::CMD_ADD, pmtt_pkg::INTERVAL_W'($urandom_range(4, 1)));
        repeat (4) queue_cmd(pmtt_pkg::CMD_TICK, pmtt_pkg::INTERVAL_W'($urandom));

        run_random(5'd16, 18, 25, 8);
        run_random(5'd5, 18, 25, 6);
        run_random(5'd1, 76, 25, 8);
        run_random(5'd12, 76, 25, 4);
        run_random(5'd31, 76, 30, 2);
        run_random(5'd0, 0, 12, 10);
        run_random(5'd16, 0, 24, 5);
        settle();

        $display("Covered %0d commands over seven limit settings; %0d result words checked,",
                 cmds_taken, words_checked);
        $display("including %0d expiries and %0d refused adds.", expiries_seen, refusals_seen);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Timed out with %0d result words still due", events_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
